@@ hw/rtl/sha256_pkg.sv @@
// SHA-256 hasher package: payload structs, round constants, initial hash values.
// Used by every module of the hasher; no dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] init_h(input logic [2:0] i);
      logic [31:0] h;
      unique case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

endpackage

@@ hw/rtl/sha256_core.sv @@
// SHA-256 compression core: one round per cycle, schedule words in a 16-word shift window.
// Block words are read from the caller's memory in the cycle before rounds 0..15 use them.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [31:0]  blk_word,
   input  logic [255:0] h_in,
   output logic [255:0] h_out,
   output logic         busy,
   output logic         done,
   output logic [3:0]   rd_addr
);

   typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FINAL} state_type;

   state_type   state_ff, state_in;
   logic [5:0]  step_ff, step_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [31:0] w_cur;
   logic        done_ff;
   logic [255:0] res_ff;

   // Schedule window: win_ff[15] is the newest word, win_ff[0] the oldest.
   logic [31:0] win_ff [16];

   logic [31:0] s0, s1, t1, t2, wn;

   assign busy = (state_ff != S_IDLE);
   assign done = done_ff;
   assign h_out = res_ff;
   // Registered read in the caller: address the word for the next round.
   assign rd_addr = step_in[3:0];

   always_comb begin
      s0 = sha256_pkg::rotr(win_ff[1], 7) ^ sha256_pkg::rotr(win_ff[1], 18)
           ^ (win_ff[1] >> 3);
      s1 = sha256_pkg::rotr(win_ff[14], 17) ^ sha256_pkg::rotr(win_ff[14], 19)
           ^ (win_ff[14] >> 10);
      wn = win_ff[0] + s0 + win_ff[9] + s1;
      w_cur = (step_ff < 6'd16) ? blk_word : wn;
      t1 = h_ff + (sha256_pkg::rotr(e_ff, 6) ^ sha256_pkg::rotr(e_ff, 11)
           ^ sha256_pkg::rotr(e_ff, 25)) + ((e_ff & f_ff) ^ (~e_ff & g_ff))
           + sha256_pkg::round_k(step_ff) + w_cur;
      t2 = (sha256_pkg::rotr(a_ff, 2) ^ sha256_pkg::rotr(a_ff, 13)
           ^ sha256_pkg::rotr(a_ff, 22)) + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
      state_in = state_ff;
      step_in = step_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            state_in = S_ROUND;
            step_in = '0;
         end
         S_ROUND: begin
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) state_in = S_FINAL;
         end
         S_FINAL: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         done_ff <= (state_ff == S_FINAL);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         {a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff} <= h_in;
      end else if (state_ff == S_ROUND) begin
         h_ff <= g_ff; g_ff <= f_ff; f_ff <= e_ff; e_ff <= d_ff + t1;
         d_ff <= c_ff; c_ff <= b_ff; b_ff <= a_ff; a_ff <= t1 + t2;
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
         win_ff[15] <= w_cur;
      end
      if (state_ff == S_FINAL) begin
         res_ff <= {h_in[255:224] + a_ff, h_in[223:192] + b_ff, h_in[191:160] + c_ff,
                    h_in[159:128] + d_ff, h_in[127:96] + e_ff, h_in[95:64] + f_ff,
                    h_in[63:32] + g_ff, h_in[31:0] + h_ff};
      end
   end

`ifndef NO_ASSERTIONS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held");
   a_final_then_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINAL |=> done) else $error("done missing");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND && step_ff != 6'd63 |=> state_ff == S_ROUND) else $error("round exit");
`endif

endmodule

@@ hw/rtl/sha256_message_hasher.sv @@
// SHA-256 message hasher, top level: block word memory, padding sequencer, digest output.
// Instantiates sha256_core; depends on sha256_pkg.
`timescale 1ns / 1ps
// Each append transaction writes one byte into the block; the 64th byte of a block starts
// a compression in the round core, during which req_ready is low. A finish transaction
// writes 0x80, then streams zero padding and the 64-bit length one byte per cycle up to
// the end of the block and compresses it; when the tail held 56 or more bytes, a second
// block of padding and length follows the first compression. After the last compression the
// eight digest words are offered on rsp_, one per accepted cycle.
module sha256_message_hasher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sha256_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sha256_pkg::rsp_type  rsp_data
);

   typedef enum logic [2:0] {S_IN, S_PAD, S_LEN, S_HASH, S_OUT} state_type;

   state_type    state_ff;
   logic [5:0]   fill_ff;
   logic [63:0]  count_ff, bits_ff;
   logic [255:0] hash_ff;
   logic         fin_ff;
   logic         len_ff;
   logic [2:0]   oidx_ff;
   logic [23:0]  part_ff;
   logic [31:0]  blk_mem [16];
   logic [31:0]  rd_ff;
   logic         core_start, core_busy, core_done;
   logic [255:0] core_h;
   logic [3:0]   rd_addr;
   logic         wr_en;
   logic [7:0]   wr_byte;
   logic         acc;

   assign acc = req_valid && req_ready;
   assign req_ready = (state_ff == S_IN);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data.digest_word = hash_ff[255 - 32*oidx_ff -: 32];
   assign rsp_data.word_index = oidx_ff;
   assign rsp_data.last_word = (oidx_ff == 3'd7);

   always_comb begin
      wr_en = 1'b0;
      wr_byte = 8'h00;
      unique case (state_ff)
         S_IN: begin
            wr_en = acc;
            wr_byte = (req_data.opcode == sha256_pkg::OP_APPEND) ? req_data.data_byte : 8'h80;
         end
         S_PAD: wr_en = 1'b1;
         S_LEN: begin
            wr_en = 1'b1;
            wr_byte = bits_ff[63:56];
         end
         default: ;
      endcase
   end

   assign core_start = wr_en && (fill_ff == 6'd63);

   sha256_core u_core (
      .clock(clock), .reset(reset), .start(core_start), .blk_word(rd_ff),
      .h_in(hash_ff), .h_out(core_h), .busy(core_busy), .done(core_done),
      .rd_addr(rd_addr)
   );

   // Bytes gather big-endian into a word; the fourth byte writes the whole word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         part_ff <= {part_ff[15:0], wr_byte};
         if (fill_ff[1:0] == 2'd3) blk_mem[fill_ff[5:2]] <= {part_ff, wr_byte};
      end
      rd_ff <= blk_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IN;
         fill_ff <= '0;
         count_ff <= '0;
         bits_ff <= '0;
         fin_ff <= 1'b0;
         len_ff <= 1'b0;
         oidx_ff <= '0;
         for (int i = 0; i < 8; i++) hash_ff[255 - 32*i -: 32] <= sha256_pkg::init_h(3'(i));
      end else begin
         if (wr_en) fill_ff <= fill_ff + 6'd1;
         unique case (state_ff)
            S_IN: if (acc) begin
               if (req_data.opcode == sha256_pkg::OP_APPEND) begin
                  count_ff <= count_ff + 64'd1;
                  if (fill_ff == 6'd63) state_ff <= S_HASH;
               end else begin
                  bits_ff <= {count_ff[60:0], 3'b000};
                  fin_ff <= 1'b1;
                  if (fill_ff == 6'd63) state_ff <= S_HASH;
                  else if (fill_ff == 6'd55) state_ff <= S_LEN;
                  else state_ff <= S_PAD;
               end
            end
            S_PAD: begin
               if (fill_ff == 6'd63) state_ff <= S_HASH;
               else if (fill_ff == 6'd55) state_ff <= S_LEN;
            end
            S_LEN: begin
               bits_ff <= {bits_ff[55:0], 8'h00};
               len_ff <= 1'b1;
               if (fill_ff == 6'd63) state_ff <= S_HASH;
            end
            S_HASH: if (core_done) begin
               hash_ff <= core_h;
               if (!fin_ff) state_ff <= S_IN;
               else if (len_ff) state_ff <= S_OUT;
               else state_ff <= S_PAD;
            end
            S_OUT: if (rsp_ready) begin
               oidx_ff <= oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_ff <= S_IN;
                  count_ff <= '0;
                  fin_ff <= 1'b0;
                  len_ff <= 1'b0;
                  for (int i = 0; i < 8; i++)
                     hash_ff[255 - 32*i -: 32] <= sha256_pkg::init_h(3'(i));
               end
            end
            default: state_ff <= S_IN;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_out: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during output");
   a_core_idle_in: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !core_busy) else $error("core busy while accepting");
   a_last_seven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_word |=> req_ready) else $error("no return");
`endif

endmodule
